### rtl/ers_pkg.sv
`timescale 1ns / 1ps

package ers_pkg;

  localparam int EXTENT_W   = 32;
  localparam int ADDR_W     = 40;
  localparam int BEATS_W    = 32;
  localparam int COUNT_W    = 64;
  localparam int MAX_PIECES = 16;
  localparam int PIECE_W    = $clog2(MAX_PIECES);

  localparam logic [2:0] KIND_BEGIN    = 3'd0;
  localparam logic [2:0] KIND_EXTENT   = 3'd1;
  localparam logic [2:0] KIND_WRITE    = 3'd2;
  localparam logic [2:0] KIND_DATA     = 3'd3;
  localparam logic [2:0] KIND_PEEK_CNT = 3'd4;
  localparam logic [2:0] KIND_PEEK_FIN = 3'd5;
  localparam logic [2:0] KIND_RESET    = 3'd6;

  localparam logic [1:0] RK_WRITE_CMD = 2'd0;
  localparam logic [1:0] RK_BYTE_CNT  = 2'd1;
  localparam logic [1:0] RK_FINISHED  = 2'd2;

  localparam logic [PIECE_W-1:0] PIECE_LAST = PIECE_W'(MAX_PIECES - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOADING,
    PH_RUNNING
  } phase_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } seq_state_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               write_mode;
    logic [4:0]         extent_count;
    logic [ADDR_W-1:0]  extent_start_bytes;
    logic [ADDR_W-1:0]  extent_len_bytes;
    logic [BEATS_W-1:0] request_beats;
    logic               end_of_packet;
  } item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [ADDR_W-1:0]  write_addr;
    logic [BEATS_W-1:0] write_beats;
    logic               last_piece;
    logic               overflow;
    logic [COUNT_W-1:0] byte_count;
    logic               finished;
  } result_t;

  // write command handed from the sequencer to the result register
  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  addr;
    logic [BEATS_W-1:0] beats;
    logic               last;
    logic               ovf;
  } cmd_t;

endpackage

### rtl/ers_ram.sv
`timescale 1ns / 1ps

module ers_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ers_seq.sv
`timescale 1ns / 1ps

module ers_seq #(
  parameter int MAX_EXTENTS     = 16,
  parameter int BEAT_BYTES_LOG2 = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  ers_pkg::item_t item,
  output logic          busy,
  output ers_pkg::cmd_t cmd
);

  import ers_pkg::*;

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int SAT_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int ENT_W = 2 * EXTENT_W;

  seq_state_t           state, state_next;
  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     expected, expected_next;
  logic [CNT_W-1:0]     store_idx, store_idx_next;
  logic [CNT_W-1:0]     load_idx, load_idx_next;
  logic [EXTENT_W-1:0]  offset, offset_next;
  logic [BEATS_W-1:0]   beats_left, beats_left_next;
  logic [PIECE_W-1:0]   piece_n, piece_n_next;

  // extent memory: {start, length} in beat units
  logic                 ram_we;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;
  logic [EXTENT_W-1:0]  ext_start;
  logic [EXTENT_W-1:0]  ext_len;

  logic [SAT_W-1:0]     cnt_wide;
  logic [CNT_W-1:0]     cnt_sat;
  logic [CNT_W:0]       store_inc;
  logic [CNT_W:0]       load_inc;
  logic                 exhausted;
  logic                 is_write;
  logic [EXTENT_W-1:0]  left;
  logic [EXTENT_W-1:0]  base;
  logic [ADDR_W-1:0]    piece_addr;
  logic [BEATS_W-1:0]   rem;
  logic                 zero_req;
  logic                 fits;
  logic                 rem_zero;
  logic                 stop_ovf;
  logic                 walk_more;

  assign ext_start  = ram_rdata[ENT_W-1 -: EXTENT_W];
  assign ext_len    = ram_rdata[EXTENT_W-1:0];

  assign cnt_wide   = SAT_W'(item.extent_count);
  assign cnt_sat    = (cnt_wide > SAT_W'(MAX_EXTENTS)) ? CNT_W'(MAX_EXTENTS)
                                                       : CNT_W'(cnt_wide);
  assign store_inc  = {1'b0, store_idx} + 1'b1;
  assign load_inc   = {1'b0, load_idx} + 1'b1;
  assign exhausted  = (load_idx >= expected);
  assign is_write   = accept && (item.kind == KIND_WRITE) && (phase == PH_RUNNING);

  assign left       = ext_len - offset;
  assign base       = ext_start + offset;
  assign piece_addr = ADDR_W'(base) << BEAT_BYTES_LOG2;
  assign rem        = beats_left - left;
  assign zero_req   = (beats_left == '0);
  assign fits       = (left > beats_left);
  assign rem_zero   = (rem == '0);
  assign stop_ovf   = (load_inc >= {1'b0, expected}) || (piece_n == PIECE_LAST);
  assign walk_more  = !zero_req && !fits && !rem_zero && !stop_ovf;

  assign busy       = (state != ST_IDLE);

  assign ram_we     = accept && (item.kind == KIND_EXTENT) && (phase == PH_LOADING)
                      && (store_idx < CNT_W'(MAX_EXTENTS));
  assign ram_wdata  = {item.extent_start_bytes[BEAT_BYTES_LOG2 +: EXTENT_W],
                       item.extent_len_bytes[BEAT_BYTES_LOG2 +: EXTENT_W]};

  // read address follows the next load index, so the read data always
  // belongs to the current load index
  ers_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_EXTENTS)
  ) u_ext_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(store_idx[IDX_W-1:0]),
    .wdata(ram_wdata),
    .raddr(load_idx_next[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (is_write && !exhausted) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!walk_more) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    expected_next   = expected;
    store_idx_next  = store_idx;
    load_idx_next   = load_idx;
    offset_next     = offset;
    beats_left_next = beats_left;
    piece_n_next    = piece_n;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.kind)
            KIND_BEGIN: begin
              if (phase == PH_IDLE && item.write_mode) begin
                expected_next  = cnt_sat;
                store_idx_next = '0;
                load_idx_next  = '0;
                offset_next    = '0;
                phase_next     = (cnt_sat == '0) ? PH_RUNNING : PH_LOADING;
              end
            end
            KIND_EXTENT: begin
              if (ram_we) begin
                store_idx_next = store_inc[CNT_W-1:0];
                if (store_inc >= {1'b0, expected}) begin
                  phase_next = PH_RUNNING;
                end
              end
            end
            KIND_WRITE: begin
              beats_left_next = item.request_beats;
              piece_n_next    = '0;
            end
            KIND_RESET: begin
              phase_next     = PH_IDLE;
              expected_next  = '0;
              store_idx_next = '0;
              load_idx_next  = '0;
              offset_next    = '0;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (!zero_req) begin
          if (fits) begin
            offset_next = offset + beats_left;
          end else begin
            load_idx_next   = load_inc[CNT_W-1:0];
            offset_next     = '0;
            beats_left_next = rem;
            piece_n_next    = piece_n + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (is_write && exhausted) begin
          cmd.valid = 1'b1;
          cmd.last  = 1'b1;
          cmd.ovf   = (item.request_beats != '0);
        end
      end
      ST_WALK: begin
        cmd.valid = 1'b1;
        cmd.addr  = piece_addr;
        if (zero_req) begin
          cmd.last = 1'b1;
        end else if (fits) begin
          cmd.beats = beats_left;
          cmd.last  = 1'b1;
        end else begin
          cmd.beats = left;
          cmd.last  = !walk_more;
          cmd.ovf   = !rem_zero && stop_ovf;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_IDLE;
      expected   <= '0;
      store_idx  <= '0;
      load_idx   <= '0;
      offset     <= '0;
      beats_left <= '0;
      piece_n    <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      expected   <= expected_next;
      store_idx  <= store_idx_next;
      load_idx   <= load_idx_next;
      offset     <= offset_next;
      beats_left <= beats_left_next;
      piece_n    <= piece_n_next;
    end
  end

endmodule

### rtl/extent_write_request_splitter_top.sv
`timescale 1ns / 1ps

// Channel   | Ports                  | Transaction taken when
// ----------+------------------------+----------------------------------
// item in   | start, busy, item      | rising edge with start=1, busy=0
// result out| strobe, result         | every cycle strobe=1 (no stall)
//
// Begin, extent, data-beat, peek and reset items leave busy low, so a new
// item can follow at once. A write request holds busy high while the walk
// runs; the extent memory is read ahead from the next load index, so the walk
// emits one piece per cycle. A request that finds the extents already used
// up answers in the accept cycle and leaves busy low.
// Each result appears on the ports in the cycle after it is formed, for one
// cycle only; the receiver cannot hold results off.
// rst clears the control state; the extent memory is not cleared and holds
// whatever was last loaded. A reset item clears less state than rst does.

module extent_write_request_splitter_top #(
  parameter int MAX_EXTENTS     = 16,
  parameter int BEAT_BYTES_LOG2 = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ers_pkg::item_t   item,
  output logic             busy,
  output logic             strobe,
  output ers_pkg::result_t result
);

  import ers_pkg::*;

  logic                accept;
  cmd_t                cmd;

  // data-beat bookkeeping
  logic [COUNT_W-1:0]  bytes_written, bytes_written_next;
  logic                finished_flag, finished_flag_next;

  // result register
  result_t             result_next;
  logic                strobe_next;

  assign accept = start && !busy;

  // phase, extent list and the request walk
  ers_seq #(
    .MAX_EXTENTS    (MAX_EXTENTS),
    .BEAT_BYTES_LOG2(BEAT_BYTES_LOG2)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (item),
    .busy  (busy),
    .cmd   (cmd)
  );

  always_comb begin
    bytes_written_next = bytes_written;
    finished_flag_next = finished_flag;
    if (accept) begin
      if (item.kind == KIND_DATA) begin
        bytes_written_next = bytes_written + (COUNT_W'(1) << BEAT_BYTES_LOG2);
        finished_flag_next = item.end_of_packet;
      end else if (item.kind == KIND_RESET) begin
        bytes_written_next = '0;
        finished_flag_next = 1'b0;
      end
    end
  end

  // a write command and a peek reply never fall in the same cycle:
  // commands come from a write request or the walk, replies from a peek
  always_comb begin
    result_next = '0;
    strobe_next = 1'b0;
    if (cmd.valid) begin
      strobe_next             = 1'b1;
      result_next.result_kind = RK_WRITE_CMD;
      result_next.write_addr  = cmd.addr;
      result_next.write_beats = cmd.beats;
      result_next.last_piece  = cmd.last;
      result_next.overflow    = cmd.ovf;
    end else if (accept && item.kind == KIND_PEEK_CNT) begin
      strobe_next             = 1'b1;
      result_next.result_kind = RK_BYTE_CNT;
      result_next.byte_count  = bytes_written;
    end else if (accept && item.kind == KIND_PEEK_FIN) begin
      strobe_next             = 1'b1;
      result_next.result_kind = RK_FINISHED;
      result_next.finished    = finished_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_written <= '0;
      finished_flag <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      bytes_written <= bytes_written_next;
      finished_flag <= finished_flag_next;
      strobe        <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
